// ===== hw/rtl/buddy_block_allocator_core_defines.svh =====
// ----------------------------------------------------------------------------
// buddy block allocator assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BBA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rst, prop, msg)
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// shared codes of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FIT    = 2'd1;
   localparam logic [1:0] ST_TOO_LARGE = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // register index, byte address bit 2
   localparam logic REG_HEADER_BYTES = 1'b0;

endpackage

// ===== hw/rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// generic synchronous ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/buddy_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// buddy allocator over a pool of top blocks, per-level lifo free lists
// ----------------------------------------------------------------------------
// After reset a clearing pass writes all TOP_BLOCKS << TOP_LEVEL entries of the
// unit table, one entry per cycle, before the first request is taken. Requests
// are handled one at a time by a sequencer around a single unit table ram
// (next link, prev link, level, used) with one read or one write per cycle.
// An allocate takes the head block of the source list, clears the back link of
// the next block on that list if there is one, then splits down to the target
// level, fixing the back link of the old head for each split into a non-empty
// list. A free checks the block and merges it with its buddy level by level
// while the buddy is free at the same level, unlinking the buddy and fixing the
// links of its list neighbors, then pushes it on its list and fixes the back
// link of the old list head. Rejected requests never write the unit table. The
// output register lets the result wait for the sink.
module buddy_block_allocator_core #(
   parameter int MIN_ORDER_BITS = 5,
   parameter int TOP_LEVEL      = 7,
   parameter int TOP_BLOCKS     = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // req_size[12:0], block_offset[26:13]
   input  logic [0:0]  req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // granted_offset[13:0], granted_level[16:14]
   output logic [1:0]  rsp_tuser,  // status
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int NUNITS = TOP_BLOCKS << TOP_LEVEL;
   localparam int UW     = $clog2(NUNITS + 1);
   localparam int AW     = (NUNITS > 1) ? $clog2(NUNITS) : 1;
   localparam int LW     = $clog2(TOP_LEVEL + 1);
   localparam int EW     = 2 * UW + LW + 1;
   localparam logic [UW-1:0] NIL    = UW'(NUNITS);
   localparam logic [UW-1:0] STRIDE = UW'(1 << TOP_LEVEL);
   localparam logic [LW-1:0] TOPL   = LW'(TOP_LEVEL);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_ALOC    = 4'd2;
   localparam logic [3:0] S_A_RDU   = 4'd3;
   localparam logic [3:0] S_A_SPLIT = 4'd4;
   localparam logic [3:0] S_F_CHK   = 4'd5;
   localparam logic [3:0] S_F_RDU   = 4'd6;
   localparam logic [3:0] S_F_LOOP  = 4'd7;
   localparam logic [3:0] S_F_RDB   = 4'd8;
   localparam logic [3:0] S_F_UN2   = 4'd9;
   localparam logic [3:0] S_F_UN3   = 4'd10;
   localparam logic [3:0] S_F_PUSH  = 4'd11;
   localparam logic [3:0] S_RMW_RD  = 4'd12;
   localparam logic [3:0] S_RMW_WR  = 4'd13;
   localparam logic [3:0] S_RESP    = 4'd14;

   typedef struct packed {
      logic [UW-1:0] nxt;
      logic [UW-1:0] prv;
      logic [LW-1:0] lvl;
      logic          used;
   } entry_type;

   logic [3:0]    state_ff, state_in;
   logic [3:0]    ret_ff, ret_in;
   logic [UW-1:0] clr_ff, clr_in;
   logic [6:0]    hdr_ff, hdr_in;
   logic          type_ff, type_in;
   logic [12:0]   size_ff, size_in;
   logic [13:0]   off_ff, off_in;
   logic [UW-1:0] u_ff, u_in;
   logic [UW-1:0] b_ff, b_in;
   logic [UW-1:0] p_ff, p_in;
   logic [UW-1:0] n_ff, n_in;
   entry_type     bent_ff, bent_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] tgt_ff, tgt_in;
   logic [UW-1:0] head_ff [TOP_LEVEL+1];
   logic [UW-1:0] head_in [TOP_LEVEL+1];
   logic [UW-1:0] rmw_addr_ff, rmw_addr_in;
   logic          rmw_prev_ff, rmw_prev_in;
   logic [UW-1:0] rmw_val_ff, rmw_val_in;
   logic [1:0]    res_st_ff, res_st_in;
   logic [UW-1:0] res_u_ff, res_u_in;
   logic [LW-1:0] res_l_ff, res_l_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;
   logic [13:0]   rsp_off_ff, rsp_off_in;
   logic [2:0]    rsp_lvl_ff, rsp_lvl_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   entry_type     ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata_raw;
   entry_type     rd;

   logic [13:0]   need;
   logic [LW-1:0] fit_lvl;
   logic          fits;
   logic [LW-1:0] src_lvl;
   logic          found;
   logic [13:0]   free_unit;
   logic          misaligned;
   logic [LW-1:0] im1;
   logic [UW-1:0] r_unit;
   logic [UW-1:0] b_unit;
   logic [UW-1:0] hd;
   logic [31:0]   ofs_wide;
   logic          cfg_we;

   assign rd = entry_type'(ram_rdata_raw);

   bba_ram #(
      .WIDTH(EW),
      .DEPTH(NUNITS)
   ) u_units (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata_raw)
   );

   assign cfg_we = psel && penable && pwrite && (paddr[2] == bba_pkg::REG_HEADER_BYTES);
   assign pready = 1'b1;
   assign prdata = (paddr[2] == bba_pkg::REG_HEADER_BYTES) ? {25'd0, hdr_ff} : 32'd0;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {7'd0, rsp_lvl_ff, rsp_off_ff};

   // size class and source list search
   always_comb begin
      need    = 14'(size_ff) + 14'(hdr_ff);
      fit_lvl = '0;
      fits    = 1'b0;
      for (int l = TOP_LEVEL; l >= 0; l--) begin
         if (32'(need) <= (32'd1 << (l + MIN_ORDER_BITS))) begin
            fit_lvl = LW'(l);
            fits    = 1'b1;
         end
      end
      src_lvl = '0;
      found   = 1'b0;
      for (int l = TOP_LEVEL; l >= 0; l--) begin
         if (LW'(l) >= fit_lvl && head_ff[l] != NIL) begin
            src_lvl = LW'(l);
            found   = 1'b1;
         end
      end
   end

   assign free_unit  = off_ff >> MIN_ORDER_BITS;
   assign misaligned = (off_ff & ((14'd1 << MIN_ORDER_BITS) - 14'd1)) != 14'd0;
   assign im1        = cur_ff - LW'(1);
   assign r_unit     = u_ff + (UW'(1) << im1);
   assign b_unit     = u_ff ^ (UW'(1) << cur_ff);
   assign hd         = (state_ff == S_A_SPLIT) ? head_ff[im1] : head_ff[cur_ff];
   assign ofs_wide   = 32'(res_u_ff) << MIN_ORDER_BITS;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      clr_in       = clr_ff;
      hdr_in       = cfg_we ? pwdata[6:0] : hdr_ff;
      type_in      = type_ff;
      size_in      = size_ff;
      off_in       = off_ff;
      u_in         = u_ff;
      b_in         = b_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      bent_in      = bent_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      head_in      = head_ff;
      rmw_addr_in  = rmw_addr_ff;
      rmw_prev_in  = rmw_prev_ff;
      rmw_val_in   = rmw_val_ff;
      res_st_in    = res_st_ff;
      res_u_in     = res_u_ff;
      res_l_in     = res_l_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_st_in    = rsp_st_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(clr_ff);
            ram_wdata = '{nxt: NIL, prv: NIL, lvl: '0, used: 1'b0};
            if ((clr_ff % STRIDE) == '0) begin
               ram_wdata.nxt = clr_ff + STRIDE;
               ram_wdata.prv = (clr_ff == '0) ? NIL : clr_ff - STRIDE;
               ram_wdata.lvl = TOPL;
            end
            clr_in = clr_ff + UW'(1);
            if (clr_ff == UW'(NUNITS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               type_in  = req_tuser[0];
               size_in  = req_tdata[12:0];
               off_in   = req_tdata[26:13];
               state_in = (req_tuser[0] == bba_pkg::REQ_FREE) ? S_F_CHK : S_ALOC;
            end
         end
         S_ALOC: begin
            res_u_in = '0;
            res_l_in = '0;
            if (size_ff == 13'd0) begin
               res_st_in = bba_pkg::ST_NO_FIT;
               state_in  = S_RESP;
            end else if (!fits) begin
               res_st_in = bba_pkg::ST_TOO_LARGE;
               state_in  = S_RESP;
            end else if (!found) begin
               res_st_in = bba_pkg::ST_NO_FIT;
               state_in  = S_RESP;
            end else begin
               u_in      = head_ff[src_lvl];
               cur_in    = src_lvl;
               tgt_in    = fit_lvl;
               ram_raddr = AW'(head_ff[src_lvl]);
               state_in  = S_A_RDU;
            end
         end
         S_A_RDU: begin
            head_in[cur_ff] = rd.nxt;
            if (rd.nxt < NIL) begin
               rmw_addr_in = rd.nxt;
               rmw_prev_in = 1'b1;
               rmw_val_in  = NIL;
               ret_in      = S_A_SPLIT;
               state_in    = S_RMW_RD;
            end else begin
               state_in = S_A_SPLIT;
            end
         end
         S_A_SPLIT: begin
            ram_we = 1'b1;
            if (cur_ff > tgt_ff) begin
               ram_waddr     = AW'(r_unit);
               ram_wdata     = '{nxt: hd, prv: NIL, lvl: im1, used: 1'b0};
               head_in[im1]  = r_unit;
               cur_in        = im1;
               if (hd < NIL) begin
                  rmw_addr_in = hd;
                  rmw_prev_in = 1'b1;
                  rmw_val_in  = r_unit;
                  ret_in      = S_A_SPLIT;
                  state_in    = S_RMW_RD;
               end
            end else begin
               ram_waddr = AW'(u_ff);
               ram_wdata = '{nxt: NIL, prv: NIL, lvl: tgt_ff, used: 1'b1};
               res_st_in = bba_pkg::ST_OK;
               res_u_in  = u_ff;
               res_l_in  = tgt_ff;
               state_in  = S_RESP;
            end
         end
         S_F_CHK: begin
            res_u_in = '0;
            res_l_in = '0;
            if (misaligned || (32'(free_unit) >= NUNITS)) begin
               res_st_in = bba_pkg::ST_NO_FIT;
               state_in  = S_RESP;
            end else begin
               u_in      = UW'(free_unit);
               ram_raddr = AW'(free_unit);
               state_in  = S_F_RDU;
            end
         end
         S_F_RDU: begin
            if (!rd.used) begin
               res_st_in = bba_pkg::ST_NO_FIT;
               state_in  = S_RESP;
            end else begin
               ram_we         = 1'b1;
               ram_waddr      = AW'(u_ff);
               ram_wdata      = rd;
               ram_wdata.used = 1'b0;
               cur_in         = (rd.lvl > TOPL) ? TOPL : rd.lvl;
               state_in       = S_F_LOOP;
            end
         end
         S_F_LOOP: begin
            if (cur_ff < TOPL && b_unit < NIL) begin
               b_in      = b_unit;
               ram_raddr = AW'(b_unit);
               state_in  = S_F_RDB;
            end else begin
               state_in = S_F_PUSH;
            end
         end
         S_F_RDB: begin
            bent_in = rd;
            if (rd.used || rd.lvl != cur_ff) begin
               state_in = S_F_PUSH;
            end else begin
               p_in = rd.prv;
               n_in = rd.nxt;
               if (rd.prv < NIL) begin
                  rmw_addr_in = rd.prv;
                  rmw_prev_in = 1'b0;
                  rmw_val_in  = rd.nxt;
                  ret_in      = S_F_UN2;
                  state_in    = S_RMW_RD;
               end else begin
                  head_in[cur_ff] = rd.nxt;
                  state_in        = S_F_UN2;
               end
            end
         end
         S_F_UN2: begin
            if (n_ff < NIL) begin
               rmw_addr_in = n_ff;
               rmw_prev_in = 1'b1;
               rmw_val_in  = p_ff;
               ret_in      = S_F_UN3;
               state_in    = S_RMW_RD;
            end else begin
               state_in = S_F_UN3;
            end
         end
         S_F_UN3: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(b_ff);
            ram_wdata = '{nxt: NIL, prv: NIL, lvl: bent_ff.lvl, used: bent_ff.used};
            if (b_ff < u_ff) begin
               u_in = b_ff;
            end
            cur_in   = cur_ff + LW'(1);
            state_in = S_F_LOOP;
         end
         S_F_PUSH: begin
            ram_we          = 1'b1;
            ram_waddr       = AW'(u_ff);
            ram_wdata       = '{nxt: hd, prv: NIL, lvl: cur_ff, used: 1'b0};
            head_in[cur_ff] = u_ff;
            res_st_in       = bba_pkg::ST_OK;
            res_u_in        = u_ff;
            res_l_in        = cur_ff;
            if (hd < NIL) begin
               rmw_addr_in = hd;
               rmw_prev_in = 1'b1;
               rmw_val_in  = u_ff;
               ret_in      = S_RESP;
               state_in    = S_RMW_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RMW_RD: begin
            ram_raddr = AW'(rmw_addr_ff);
            state_in  = S_RMW_WR;
         end
         S_RMW_WR: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(rmw_addr_ff);
            ram_wdata = rd;
            if (rmw_prev_ff) begin
               ram_wdata.prv = rmw_val_ff;
            end else begin
               ram_wdata.nxt = rmw_val_ff;
            end
            state_in = ret_ff;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_off_in   = ofs_wide[13:0];
               rsp_lvl_in   = 3'(res_l_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_IDLE;
         clr_ff       <= '0;
         hdr_ff       <= 7'd24;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l <= TOP_LEVEL; l++) begin
            head_ff[l] <= (l == TOP_LEVEL) ? '0 : NIL;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         clr_ff       <= clr_in;
         hdr_ff       <= hdr_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      size_ff     <= size_in;
      off_ff      <= off_in;
      u_ff        <= u_in;
      b_ff        <= b_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      bent_ff     <= bent_in;
      cur_ff      <= cur_in;
      tgt_ff      <= tgt_in;
      rmw_addr_ff <= rmw_addr_in;
      rmw_prev_ff <= rmw_prev_in;
      rmw_val_ff  <= rmw_val_in;
      res_st_ff   <= res_st_in;
      res_u_ff    <= res_u_in;
      res_l_ff    <= res_l_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_lvl_ff  <= rsp_lvl_in;
   end

`include "buddy_block_allocator_core_defines.svh"

   `BBA_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")
   `BBA_ASSERT(a_clear_blocks, clock, reset, state_ff == S_CLEAR |-> !req_tready, "request taken during clearing pass")
   `BBA_ASSERT(a_rsp_from_seq, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff == S_RESP), "result not from sequencer")
   `BBA_ASSERT(a_fail_zero, clock, reset, rsp_tvalid && rsp_tuser != bba_pkg::ST_OK |-> rsp_tdata == 24'd0, "failed result carries data")
   `BBA_ASSERT_ALWAYS(a_type_known, clock, (state_ff == S_F_CHK) |-> (type_ff == bba_pkg::REQ_FREE), "free path without free request")

endmodule

// ===== tb/buddy_block_allocator_core_checker.sv =====
// ----------------------------------------------------------------------------
// buddy block allocator checker
// watches the request, result and register ports, keeps its own copy of the
// free lists and unit table, and compares every result with its prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buddy_block_allocator_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          errors,
   output int          pending,
   output int          results_seen,
   output int          merges_seen
);

   localparam int MOB    = 5;
   localparam int TOPL   = 7;
   localparam int NTOP   = 4;
   localparam int NUNITS = NTOP << TOPL;
   localparam int NIL    = NUNITS;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] offset;
      logic [2:0]  level;
   } grant_type;

   int          head [TOPL+1];
   int          nxt [NUNITS];
   int          prv [NUNITS];
   int          unit_lvl [NUNITS];
   bit          unit_busy [NUNITS];
   logic [6:0]  hdr_bytes;
   grant_type   grants_due [$];

   function automatic void pool_reset();
      hdr_bytes = 7'd24;
      for (int i = 0; i <= TOPL; i++) head[i] = NIL;
      for (int i = 0; i < NUNITS; i++) begin
         nxt[i] = NIL;
         prv[i] = NIL;
         unit_lvl[i] = 0;
         unit_busy[i] = 0;
      end
      for (int k = 0; k < NTOP; k++) begin
         unit_lvl[k << TOPL] = TOPL;
         nxt[k << TOPL] = (k + 1 < NTOP) ? ((k + 1) << TOPL) : NIL;
         prv[k << TOPL] = (k > 0) ? ((k - 1) << TOPL) : NIL;
      end
      head[TOPL] = 0;
   endfunction

   function automatic void list_push(int l, int u);
      int h;
      h = head[l];
      nxt[u] = h;
      prv[u] = NIL;
      if (h < NUNITS) prv[h] = u;
      head[l] = u;
   endfunction

   function automatic void list_drop(int l, int u);
      int p, n;
      p = prv[u];
      n = nxt[u];
      if (p < NUNITS) nxt[p] = n;
      else head[l] = n;
      if (n < NUNITS) prv[n] = p;
      nxt[u] = NIL;
      prv[u] = NIL;
   endfunction

   function automatic grant_type make_grant(logic [1:0] st, int u, int l);
      grant_type g;
      g.status = st;
      g.offset = 14'((u << MOB) & 16'h3fff);
      g.level  = 3'(l);
      return g;
   endfunction

   function automatic grant_type predict_grant(logic kind, int size, int off);
      int need, l, i, u, r, b;
      if (kind == bba_pkg::REQ_ALLOC) begin
         if (size == 0) return make_grant(bba_pkg::ST_NO_FIT, 0, 0);
         need = size + hdr_bytes;
         l = 0;
         while (l <= TOPL && need > (1 << (l + MOB))) l++;
         if (l > TOPL) return make_grant(bba_pkg::ST_TOO_LARGE, 0, 0);
         i = l;
         while (i <= TOPL && head[i] >= NUNITS) i++;
         if (i > TOPL) return make_grant(bba_pkg::ST_NO_FIT, 0, 0);
         u = head[i];
         list_drop(i, u);
         while (i > l) begin
            i--;
            r = u + (1 << i);
            unit_lvl[r] = i;
            unit_busy[r] = 0;
            list_push(i, r);
         end
         unit_lvl[u] = l;
         unit_busy[u] = 1;
         return make_grant(bba_pkg::ST_OK, u, l);
      end
      if ((off & ((1 << MOB) - 1)) != 0) return make_grant(bba_pkg::ST_NO_FIT, 0, 0);
      u = off >> MOB;
      if (u >= NUNITS || !unit_busy[u]) return make_grant(bba_pkg::ST_NO_FIT, 0, 0);
      unit_busy[u] = 0;
      l = unit_lvl[u];
      if (l > TOPL) l = TOPL;
      while (l < TOPL) begin
         b = u ^ (1 << l);
         if (b >= NUNITS || unit_busy[b] || unit_lvl[b] != l) break;
         list_drop(l, b);
         if (b < u) u = b;
         l++;
         unit_lvl[u] = l;
         merges_seen++;
      end
      unit_lvl[u] = l;
      unit_busy[u] = 0;
      list_push(l, u);
      return make_grant(bba_pkg::ST_OK, u, l);
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
      errors++;
   endtask

   initial begin
      errors = 0;
      pending = 0;
      results_seen = 0;
      merges_seen = 0;
      pool_reset();
   end

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         pool_reset();
         grants_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (grants_due.size() == 0) begin
               report("outstanding results", 1, 0);
            end else begin
               want = grants_due.pop_front();
               if (rsp_tuser !== want.status) report("status", rsp_tuser, want.status);
               if (rsp_tdata[13:0] !== want.offset)
                  report("granted_offset", rsp_tdata[13:0], want.offset);
               if (rsp_tdata[16:14] !== want.level)
                  report("granted_level", rsp_tdata[16:14], want.level);
            end
         end
         if (req_tvalid && req_tready)
            grants_due.push_back(predict_grant(req_tuser[0], int'(req_tdata[12:0]),
                                               int'(req_tdata[26:13])));
         if (psel && penable && pwrite && pready && paddr[2] == bba_pkg::REG_HEADER_BYTES)
            hdr_bytes = pwdata[6:0];
      end
      pending = grants_due.size();
   end

endmodule

// ===== tb/buddy_block_allocator_core_test.sv =====
// ----------------------------------------------------------------------------
// buddy block allocator testbench
// directed corner requests, then random allocate and free traffic under
// several header sizes with random gaps and sink stalls, checked by a model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buddy_block_allocator_core_test;

   localparam int LIMIT = 800000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // req_size[12:0], block_offset[26:13]
   logic [0:0]  req_tuser;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // granted_offset[13:0], granted_level[16:14]
   logic [1:0]  rsp_tuser;   // status
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int          errors, pending, results_seen, merges_seen;
   int          cycles;
   int          sent;
   bit          calm;
   bit          hold_now;
   logic        kinds_sent [$];
   logic [13:0] live [$];
   logic [13:0] last_freed;

   buddy_block_allocator_core u_top (.*);

   buddy_block_allocator_core_checker u_check (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // track granted blocks so frees can name live ones
   always @(posedge clock) begin
      logic k;
      if (!reset && rsp_tvalid && rsp_tready && kinds_sent.size() != 0) begin
         k = kinds_sent.pop_front();
         if (k == bba_pkg::REQ_ALLOC && rsp_tuser == bba_pkg::ST_OK)
            live.push_back(rsp_tdata[13:0]);
      end
   end

   // sink side
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_now) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_now = 0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send(logic kind, int size, int off);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, 14'(off), 13'(size)};
      do @(posedge clock); while (!req_tready);
      kinds_sent.push_back(kind);
      sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic free_live();
      int idx;
      logic [13:0] off;
      idx = $urandom_range(0, live.size() - 1);
      off = live[idx];
      live.delete(idx);
      last_freed = off;
      send(bba_pkg::REQ_FREE, $urandom_range(0, 8191), off);
   endtask

   task automatic random_phase(int count, int free_pct);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (live.size() != 0 && r < free_pct) free_live();
         else if (r < free_pct + 6) begin
            case ($urandom_range(0, 2))
               0: send(bba_pkg::REQ_FREE, $urandom_range(0, 8191), $urandom_range(0, 16383));
               1: send(bba_pkg::REQ_FREE, 0, last_freed);
               default: send(bba_pkg::REQ_FREE, 0, $urandom_range(0, 511) << 5);
            endcase
         end else begin
            r = $urandom_range(0, 99);
            if (r < 80) send(bba_pkg::REQ_ALLOC, $urandom_range(1, 120), 0);
            else if (r < 94) send(bba_pkg::REQ_ALLOC, $urandom_range(121, 4096),
                                  $urandom_range(0, 16383));
            else if (r < 97) send(bba_pkg::REQ_ALLOC, $urandom_range(4097, 8191), 0);
            else send(bba_pkg::REQ_ALLOC, 0, 0);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      cycles = 0;
      sent = 0;
      calm = 0;
      hold_now = 0;
      last_freed = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corner requests under the reset header size
      send(bba_pkg::REQ_ALLOC, 0, 0);
      send(bba_pkg::REQ_ALLOC, 8191, 16383);
      send(bba_pkg::REQ_ALLOC, 4073, 0);
      send(bba_pkg::REQ_ALLOC, 1, 0);
      send(bba_pkg::REQ_ALLOC, 8, 0);
      send(bba_pkg::REQ_ALLOC, 40, 0);
      settle();
      while (live.size() != 0) free_live();
      send(bba_pkg::REQ_FREE, 0, 16383);
      send(bba_pkg::REQ_FREE, 0, 16352);
      settle();
      repeat (4) send(bba_pkg::REQ_ALLOC, 4072, 0);
      send(bba_pkg::REQ_ALLOC, 1, 0);
      settle();
      while (live.size() != 0) free_live();
      send(bba_pkg::REQ_FREE, 0, last_freed);
      settle();

      csr_write(3'd0, 32'd0);
      hold_now = 1;
      random_phase(400, 35);
      settle();
      csr_write(3'd0, 32'd64);
      random_phase(400, 50);
      settle();
      csr_write(3'd0, 32'($urandom_range(1, 63)));
      random_phase(400, 45);
      settle();
      csr_write(3'd0, 32'd24);
      calm = 1;
      random_phase(350, 45);
      while (live.size() != 0) free_live();
      settle();

      $display("%0d requests sent, %0d results checked, %0d buddy merges", sent,
               results_seen, merges_seen);
      $display("header sizes 24, 0, 64 and one random; one long sink hold");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
